FILE: design/tee_pkg.sv
// ----------------------------------------------------------------------------
// tee_pkg
// Shared constants, widths, register indexes and rounding helpers for the
// total energy control error computer.
// ----------------------------------------------------------------------------
package tee_pkg;

  // Width that each potential or kinetic energy term saturates to.
  localparam int unsigned EW    = 32;
  localparam int unsigned EW1   = EW + 1;   // energy difference
  localparam int unsigned EW2   = EW + 2;   // sum of two differences
  localparam int unsigned BP_W  = EW + 16;  // weight times difference
  localparam int unsigned BD_W  = EW + 17;  // difference of two weighted terms
  localparam int unsigned BR_W  = BD_W - 12; // balance error after rounding

  localparam int unsigned LATENCY = 7;

  localparam logic signed [20:0] GRAVITY_Q16  = 21'sd642712;
  localparam logic [15:0]        MASS_DEFAULT = 16'd640;
  localparam logic [15:0]        MASS_FLOOR   = 16'd3;
  localparam logic [13:0]        WEIGHT_MAX   = 14'd8192;
  localparam logic [13:0]        WEIGHT_TWO   = 14'd8192;

  typedef enum logic [1:0] {
    CFG_MASS   = 2'd0,
    CFG_WEIGHT = 2'd1,
    CFG_SPDMIN = 2'd2,
    CFG_SPDMAX = 2'd3
  } cfg_idx_e;

  localparam logic signed [63:0] E_MAX   = (64'sd1 <<< (EW - 1)) - 64'sd1;
  localparam logic signed [63:0] E_MIN   = -E_MAX - 64'sd1;
  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -S32_MAX - 64'sd1;

  // Round half up by sh bits, then saturate to an energy term.
  function automatic logic signed [EW-1:0] rnd_sat_e(input logic signed [63:0] x,
                                                      input int unsigned sh);
    logic signed [63:0] r;
    r = (x + (64'sd1 <<< (sh - 1))) >>> sh;
    if (r > E_MAX) begin
      r = E_MAX;
    end else if (r < E_MIN) begin
      r = E_MIN;
    end
    return EW'(r);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [63:0] r;
    r = x;
    if (r > S32_MAX) begin
      r = S32_MAX;
    end else if (r < S32_MIN) begin
      r = S32_MIN;
    end
    return 32'(r);
  endfunction

endpackage

FILE: design/tecs_energy_error.sv
// ----------------------------------------------------------------------------
// tecs_energy_error
// Pipelined total and balance energy error computer for a total energy
// control loop.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: present target/measured speed and height and raise
//   start_i; a transfer happens at every rising edge with start_i high and
//   busy_o low. busy_o never rises: the seven stage pipeline takes a new
//   sample set every cycle, so one item per cycle is sustained.
//   Result channel: done_o is high for exactly one cycle, after the item
//   has passed all stages, with total_error_o and balance_error_o valid in that cycle.
//   Results come out in order; the receiver cannot stall them.
//   Configuration: cfg_we_i/cfg_idx_i/cfg_data_i write vehicle mass, balance
//   weight and the speed window, one register per cycle, while no item is
//   in flight. Each item samples the configuration at its transfer.
//   Reset: rst_ni low clears all pipeline valid bits and loads the register
//   defaults (2.5 kg, weight 0, window 0..0); no result is emitted.
//   Pipeline: (1) mass*height and speed squares, (2) times g and times mass,
//   (3) round and saturate energies, (4) energy errors, (5) weighting
//   products, (6) balance difference and rounding, (7) clamp and saturate.
// ----------------------------------------------------------------------------
module tecs_energy_error
  import tee_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic signed [15:0] target_speed_i,
  input  logic signed [23:0] target_height_i,
  input  logic signed [15:0] measured_speed_i,
  input  logic signed [23:0] measured_height_i,
  output logic               done_o,
  output logic signed [31:0] total_error_o,
  output logic signed [31:0] balance_error_o
);

  // Configuration registers
  logic [15:0]        vehicle_mass_q;
  logic signed [15:0] balance_weight_q;
  logic signed [15:0] speed_min_q;
  logic signed [15:0] speed_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vehicle_mass_q   <= MASS_DEFAULT;
      balance_weight_q <= '0;
      speed_min_q      <= '0;
      speed_max_q      <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MASS:   vehicle_mass_q   <= cfg_data_i;
        CFG_WEIGHT: balance_weight_q <= cfg_data_i;
        CFG_SPDMIN: speed_min_q      <= cfg_data_i;
        CFG_SPDMAX: speed_max_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The pipeline never holds off a transfer.
  assign busy_o = 1'b0;

  logic accept;
  assign accept = start_i && !busy_o;

  // Stage 1: effective mass and weight, mass*height, speed squares
  logic [15:0]        mass_eff;
  logic [13:0]        w_eff;
  logic signed [31:0] sq_ref, sq_meas, sq_min, sq_max;

  always_comb begin
    mass_eff = (vehicle_mass_q < MASS_FLOOR) ? MASS_DEFAULT : vehicle_mass_q;
    if (balance_weight_q[15]) begin
      w_eff = '0;
    end else if (balance_weight_q > $signed({2'b00, WEIGHT_MAX})) begin
      w_eff = WEIGHT_MAX;
    end else begin
      w_eff = balance_weight_q[13:0];
    end
    sq_ref  = 32'(target_speed_i) * 32'(target_speed_i);
    sq_meas = 32'(measured_speed_i) * 32'(measured_speed_i);
    sq_min  = 32'(speed_min_q) * 32'(speed_min_q);
    sq_max  = 32'(speed_max_q) * 32'(speed_max_q);
  end

  logic               s1_vld_q;
  logic signed [40:0] mh_ref_q, mh_meas_q;
  logic [30:0]        vv_ref_q, vv_meas_q, vv_min_q, vv_max_q;
  logic [15:0]        mass1_q;
  logic [13:0]        w1_q;

  always_ff @(posedge clk_i) begin
    mh_ref_q  <= 41'($signed({1'b0, mass_eff})) * 41'(target_height_i);
    mh_meas_q <= 41'($signed({1'b0, mass_eff})) * 41'(measured_height_i);
    vv_ref_q  <= sq_ref[30:0];
    vv_meas_q <= sq_meas[30:0];
    vv_min_q  <= sq_min[30:0];
    vv_max_q  <= sq_max[30:0];
    mass1_q   <= mass_eff;
    w1_q      <= w_eff;
  end

  // Stage 2: potential product times g (Q.32), kinetic times mass (Q.25)
  logic               s2_vld_q;
  logic signed [61:0] pe_ref_q, pe_meas_q;
  logic [46:0]        ke_ref_q, ke_meas_q, ke_min_q, ke_max_q;
  logic [13:0]        w2_q;

  always_ff @(posedge clk_i) begin
    pe_ref_q  <= 62'(mh_ref_q) * 62'(GRAVITY_Q16);
    pe_meas_q <= 62'(mh_meas_q) * 62'(GRAVITY_Q16);
    ke_ref_q  <= 47'(vv_ref_q) * 47'(mass1_q);
    ke_meas_q <= 47'(vv_meas_q) * 47'(mass1_q);
    ke_min_q  <= 47'(vv_min_q) * 47'(mass1_q);
    ke_max_q  <= 47'(vv_max_q) * 47'(mass1_q);
    w2_q      <= w1_q;
  end

  // Stage 3: round to Q.8 and saturate each energy term
  logic                 s3_vld_q;
  logic signed [EW-1:0] ep_ref_q, ep_meas_q, ek_ref_q, ek_meas_q, ek_min_q, ek_max_q;
  logic [13:0]          w3_q;

  always_ff @(posedge clk_i) begin
    ep_ref_q  <= rnd_sat_e(64'(pe_ref_q), 24);
    ep_meas_q <= rnd_sat_e(64'(pe_meas_q), 24);
    ek_ref_q  <= rnd_sat_e($signed({17'd0, ke_ref_q}), 17);
    ek_meas_q <= rnd_sat_e($signed({17'd0, ke_meas_q}), 17);
    ek_min_q  <= rnd_sat_e($signed({17'd0, ke_min_q}), 17);
    ek_max_q  <= rnd_sat_e($signed({17'd0, ke_max_q}), 17);
    w3_q      <= w2_q;
  end

  // Stage 4: energy errors, window bounds and total
  logic                  s4_vld_q;
  logic signed [EW1-1:0] err_pot_q, err_kin_q, lo4_q, hi4_q;
  logic signed [EW2-1:0] tot4_q;
  logic [13:0]           w4_q;
  logic signed [EW1-1:0] err_pot_d, err_kin_d;

  always_comb begin
    err_pot_d = EW1'(ep_ref_q) - EW1'(ep_meas_q);
    err_kin_d = EW1'(ek_ref_q) - EW1'(ek_meas_q);
  end

  always_ff @(posedge clk_i) begin
    err_pot_q <= err_pot_d;
    err_kin_q <= err_kin_d;
    lo4_q     <= EW1'(ek_min_q) - EW1'(ek_meas_q);
    hi4_q     <= EW1'(ek_max_q) - EW1'(ek_meas_q);
    tot4_q    <= EW2'(err_pot_d) + EW2'(err_kin_d);
    w4_q      <= w3_q;
  end

  // Stage 5: weighting products (Q.20)
  logic                  s5_vld_q;
  logic signed [BP_W-1:0] pk_q, pw_q;
  logic signed [EW1-1:0] lo5_q, hi5_q;
  logic signed [EW2-1:0] tot5_q;
  logic [13:0]           kw;

  assign kw = WEIGHT_TWO - w4_q;

  always_ff @(posedge clk_i) begin
    pk_q   <= BP_W'($signed({1'b0, kw})) * BP_W'(err_kin_q);
    pw_q   <= BP_W'($signed({1'b0, w4_q})) * BP_W'(err_pot_q);
    lo5_q  <= lo4_q;
    hi5_q  <= hi4_q;
    tot5_q <= tot4_q;
  end

  // Stage 6: balance difference, round Q.20 to Q.8
  logic                   s6_vld_q;
  logic signed [BD_W-1:0] bd, bd_r;
  logic signed [BR_W-1:0] bal6_q;
  logic signed [EW1-1:0]  lo6_q, hi6_q;
  logic signed [EW2-1:0]  tot6_q;

  always_comb begin
    bd   = BD_W'(pk_q) - BD_W'(pw_q);
    bd_r = (bd + BD_W'(2048)) >>> 12;
  end

  always_ff @(posedge clk_i) begin
    bal6_q <= bd_r[BR_W-1:0];
    lo6_q  <= lo5_q;
    hi6_q  <= hi5_q;
    tot6_q <= tot5_q;
  end

  // Stage 7: clamp balance into the kinetic window (lower bound first), cap total at the upper bound, saturate
  logic signed [BR_W-1:0] bal_c;
  logic signed [EW2-1:0]  tot_c;

  always_comb begin
    bal_c = bal6_q;
    if (bal_c < BR_W'(lo6_q)) begin
      bal_c = BR_W'(lo6_q);
    end
    if (bal_c > BR_W'(hi6_q)) begin
      bal_c = BR_W'(hi6_q);
    end
    tot_c = tot6_q;
    if (tot_c > EW2'(hi6_q)) begin
      tot_c = EW2'(hi6_q);
    end
  end

  logic               done_q;
  logic signed [31:0] total_error_q, balance_error_q;

  always_ff @(posedge clk_i) begin
    total_error_q   <= sat32(64'(tot_c));
    balance_error_q <= sat32(64'(bal_c));
  end

  // Valid bits travel alongside the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
      s6_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      s1_vld_q <= accept;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
      s5_vld_q <= s4_vld_q;
      s6_vld_q <= s5_vld_q;
      done_q   <= s6_vld_q;
    end
  end

  assign done_o          = done_q;
  assign total_error_o   = total_error_q;
  assign balance_error_o = balance_error_q;

endmodule

FILE: design/tee_checker.sv
// ----------------------------------------------------------------------------
// tee_checker
// Port level checks on latency and determinism of the energy error block.
// ----------------------------------------------------------------------------
module tee_checker
  import tee_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_i,
  input logic               cfg_we_i,
  input logic signed [15:0] target_speed_i,
  input logic signed [23:0] target_height_i,
  input logic signed [15:0] measured_speed_i,
  input logic signed [23:0] measured_height_i,
  input logic               done_i,
  input logic signed [31:0] total_error_i,
  input logic signed [31:0] balance_error_i
);

  // Every transfer yields a matching result.
  a_lat_fwd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_i) |-> ##LATENCY done_i)
    else $error("transfer without result");

  // No result appears without a matching transfer.
  a_lat_bwd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |-> $past(start_i && !busy_i, LATENCY))
    else $error("result without transfer");

  // Back to back identical items under unchanged configuration agree.
  a_same : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_i && $past(done_i) && !$past(cfg_we_i, LATENCY + 1) &&
     $past(target_speed_i, LATENCY) == $past(target_speed_i, LATENCY + 1) &&
     $past(target_height_i, LATENCY) == $past(target_height_i, LATENCY + 1) &&
     $past(measured_speed_i, LATENCY) == $past(measured_speed_i, LATENCY + 1) &&
     $past(measured_height_i, LATENCY) == $past(measured_height_i, LATENCY + 1))
    |-> ($stable(total_error_i) && $stable(balance_error_i)))
    else $error("identical items gave different results");

endmodule

bind tecs_energy_error tee_checker u_tee_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .start_i           (start_i),
  .busy_i            (busy_o),
  .cfg_we_i          (cfg_we_i),
  .target_speed_i    (target_speed_i),
  .target_height_i   (target_height_i),
  .measured_speed_i  (measured_speed_i),
  .measured_height_i (measured_height_i),
  .done_i            (done_o),
  .total_error_i     (total_error_o),
  .balance_error_i   (balance_error_o)
);
